// File: src/opg_pkg.sv
// Shared types, constants and arithmetic helpers of the orbit point generator.
`default_nettype none

package opg_pkg;

  localparam int unsigned COORD_W = 44;
  localparam int unsigned OUT_W   = 48;
  localparam int unsigned WIDE_W  = 54;

  typedef logic signed [31:0]        trig_t;
  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic signed [WIDE_W-1:0]  wide_t;

  // Two partial products of a length and a Q1.30 trig value.
  typedef struct packed {
    logic signed [COORD_W+11:0] hi;
    logic signed [52:0]         lo;
  } pp_t;

  typedef struct packed {
    logic [OUT_W-1:0] value;
    logic             clip;
  } emit_t;

  typedef enum logic [2:0] {
    REG_SMA   = 3'd0,
    REG_ECC   = 3'd1,
    REG_INC   = 3'd2,
    REG_NODE  = 3'd3,
    REG_PERI  = 3'd4,
    REG_COUNT = 3'd5
  } reg_index_t;

  localparam trig_t       CORDIC_GAIN  = 32'sh26DD3B6A;
  localparam logic [39:0] RADIUS_LIMIT = 40'hFF_FFFF_FFFF;

  localparam logic [31:0] ATAN_BAM [0:31] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
    32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
    32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
    32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
  };

  // The length is split at bit 20 so that the products are 24 by 32 and 21 by 32 bits.
  function automatic pp_t pp_mul(coord_t a, trig_t t);
    logic signed [COORD_W-21:0] ah;
    logic signed [20:0]         al;
    pp_t                        p;
    ah = a[COORD_W-1:20];
    al = {1'b0, a[19:0]};
    p.hi = ah * t;
    p.lo = al * t;
    return p;
  endfunction

  // Floor of length times trig over 2^30, rebuilt from the partial products.
  function automatic coord_t pp_join(pp_t p);
    logic [COORD_W+12:0] s;
    s = {p.hi[COORD_W+11], p.hi} + {{(COORD_W-20){p.lo[52]}}, p.lo[52:20]};
    return s[COORD_W+9:10];
  endfunction

  function automatic wide_t times_1000(coord_t v);
    wide_t ve;
    ve = {{(WIDE_W-COORD_W){v[COORD_W-1]}}, v};
    return (ve <<< 10) - (ve <<< 4) - (ve <<< 3);
  endfunction

  function automatic emit_t clamp_out(wide_t w);
    emit_t e;
    if (w[WIDE_W-1:OUT_W-1] == {(WIDE_W-OUT_W+1){w[WIDE_W-1]}}) begin
      e.value = w[OUT_W-1:0];
      e.clip  = 1'b0;
    end else begin
      e.value = w[WIDE_W-1] ? {1'b1, {(OUT_W-1){1'b0}}} : {1'b0, {(OUT_W-1){1'b1}}};
      e.clip  = 1'b1;
    end
    return e;
  endfunction

endpackage

`default_nettype wire

// File: src/opg_div.sv
// Pipelined restoring divider, SPS quotient bits per stage (the last stage may do fewer).
`default_nettype none

module opg_div
  import opg_pkg::*;
#(
  parameter int unsigned NBITS = 48,
  parameter int unsigned RW = 17,
  parameter int unsigned QW = 32,
  parameter int unsigned SPS = 3,
  localparam int unsigned STAGES = (NBITS + SPS - 1) / SPS
) (
  input  wire logic              clk,
  input  wire logic [STAGES-1:0] stage_en,
  input  wire logic [RW-1:0]     rem_in,
  input  wire logic [NBITS-1:0]  bits_in,
  input  wire logic [RW-1:0]     divisor,
  output logic      [QW-1:0]     quotient
);

  logic [RW-1:0]    rr [STAGES];
  logic [NBITS-1:0] br [STAGES];
  logic [QW-1:0]    qr [STAGES];
  logic [RW-1:0]    dr [STAGES];

  for (genvar s = 0; s < STAGES; s++) begin : g_stage
    logic [RW-1:0]    r_in;
    logic [NBITS-1:0] b_in;
    logic [QW-1:0]    q_in;
    logic [RW-1:0]    d_in;
    logic [RW-1:0]    r_nx;
    logic [NBITS-1:0] b_nx;
    logic [QW-1:0]    q_nx;

    if (s == 0) begin : g_first
      assign r_in = rem_in;
      assign b_in = bits_in;
      assign q_in = '0;
      assign d_in = divisor;
    end else begin : g_next
      assign r_in = rr[s-1];
      assign b_in = br[s-1];
      assign q_in = qr[s-1];
      assign d_in = dr[s-1];
    end

    always_comb begin : step
      logic [RW:0] t;
      r_nx = r_in;
      b_nx = b_in;
      q_nx = q_in;
      for (int j = 0; j < SPS; j++) begin
        if (s * SPS + j < NBITS) begin
          t    = {r_nx, b_nx[NBITS-1]};
          b_nx = {b_nx[NBITS-2:0], 1'b0};
          if (t >= {1'b0, d_in}) begin
            t    = t - {1'b0, d_in};
            q_nx = {q_nx[QW-2:0], 1'b1};
          end else begin
            q_nx = {q_nx[QW-2:0], 1'b0};
          end
          r_nx = t[RW-1:0];
        end
      end
    end

    always_ff @(posedge clk) begin
      if (stage_en[s]) begin
        rr[s] <= r_nx;
        br[s] <= b_nx;
        qr[s] <= q_nx;
        dr[s] <= d_in;
      end
    end
  end

  assign quotient = qr[STAGES-1];

endmodule

`default_nettype wire

// File: src/opg_cordic.sv
// Pipelined rotation-mode CORDIC giving Q1.30 cosine and sine of a binary angle.
`default_nettype none

module opg_cordic
  import opg_pkg::*;
#(
  parameter int unsigned ITERATIONS = 16,
  localparam int unsigned NI = (ITERATIONS + 1) / 2,
  localparam int unsigned STAGES = NI + 1
) (
  input  wire logic              clk,
  input  wire logic [STAGES-1:0] stage_en,
  input  wire logic [31:0]       angle,
  output trig_t                  cos_val,
  output trig_t                  sin_val
);

  trig_t xr [NI];
  trig_t yr [NI];
  trig_t zr [NI];
  logic  fr [NI];

  for (genvar s = 0; s < NI; s++) begin : g_stage
    trig_t x_in, y_in, z_in;
    logic  f_in;
    trig_t x_nx, y_nx, z_nx;

    if (s == 0) begin : g_first
      // Angles in the second and third quadrant are turned by half a turn
      // and the results negated at the end.
      assign f_in = (angle[31:30] == 2'b01) || (angle[31:30] == 2'b10);
      assign x_in = CORDIC_GAIN;
      assign y_in = '0;
      assign z_in = f_in ? (angle ^ 32'h8000_0000) : angle;
    end else begin : g_next
      assign f_in = fr[s-1];
      assign x_in = xr[s-1];
      assign y_in = yr[s-1];
      assign z_in = zr[s-1];
    end

    always_comb begin : iter
      trig_t dx, dy;
      x_nx = x_in;
      y_nx = y_in;
      z_nx = z_in;
      for (int j = 0; j < 2; j++) begin
        if (2 * s + j < ITERATIONS) begin
          dx = y_nx >>> (2 * s + j);
          dy = x_nx >>> (2 * s + j);
          if (!z_nx[31]) begin
            x_nx = x_nx - dx;
            y_nx = y_nx + dy;
            z_nx = z_nx - $signed(ATAN_BAM[2 * s + j]);
          end else begin
            x_nx = x_nx + dx;
            y_nx = y_nx - dy;
            z_nx = z_nx + $signed(ATAN_BAM[2 * s + j]);
          end
        end
      end
    end

    always_ff @(posedge clk) begin
      if (stage_en[s]) begin
        xr[s] <= x_nx;
        yr[s] <= y_nx;
        zr[s] <= z_nx;
        fr[s] <= f_in;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (stage_en[NI]) begin
      cos_val <= fr[NI-1] ? -xr[NI-1] : xr[NI-1];
      sin_val <= fr[NI-1] ? -yr[NI-1] : yr[NI-1];
    end
  end

endmodule

`default_nettype wire

// File: src/orbit_point_generator_unit.sv
// Orbit point generator: scaled 3-D position of one point on a conic orbit.
//
// The orbit is set through the APB-style register port while the block is
// idle: semi-major axis, eccentricity, inclination, node, periapsis and count.
// An item on the input channel is a point index; it is taken when in_valid is
// high and in_stall is low. Each item gives exactly one result on the output
// channel (pos_x, pos_up, pos_depth, saturated), taken when out_valid is high
// and out_stall is low. Results leave in the order the items came in.
// One item is taken every cycle while in_stall is low; the rate is set by the
// fully pipelined dividers and CORDIC. When the receiver stalls, one more item
// is held in a skid register and then the whole pipeline freezes with in_stall
// high; nothing is lost or repeated. Reset empties the pipeline and returns the
// registers to their reset values (point count one, everything else zero). The
// trig values of the register angles settle after a write in free-running CORDIC
// units, before any item taken after the write needs them.
`default_nettype none

module orbit_point_generator_unit
  import opg_pkg::*;
#(
  parameter int unsigned TRIG_ITERATIONS = 16,
  parameter int unsigned INDEX_WIDTH = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [15:0] point_index,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic signed [47:0] pos_x,
  output logic signed [47:0] pos_up,
  output logic signed [47:0] pos_depth,
  output logic             saturated
);

  localparam int unsigned DIV_SPS    = 3;
  localparam int unsigned THETA_BITS = INDEX_WIDTH + 32;
  localparam int unsigned ND         = (THETA_BITS + DIV_SPS - 1) / DIV_SPS;
  localparam int unsigned NC         = (TRIG_ITERATIONS + 1) / 2 + 1;
  localparam int unsigned RAD_SPS    = 2;
  localparam int unsigned RAD_BITS   = 40;
  localparam int unsigned NR         = (RAD_BITS + RAD_SPS - 1) / RAD_SPS;
  localparam int unsigned S_RP0      = ND + NC;
  localparam int unsigned S_M0       = S_RP0 + 3 + NR;
  localparam int unsigned NSTG       = S_M0 + 10;

  // Configuration registers.
  logic [31:0] sma;
  logic [15:0] ecc;
  logic [15:0] inc;
  logic [15:0] node;
  logic [15:0] peri;
  logic [16:0] cnt;
  logic        wr;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      sma  <= '0;
      ecc  <= '0;
      inc  <= '0;
      node <= '0;
      peri <= '0;
      cnt  <= 17'd1;
    end else if (wr) begin
      case (reg_index_t'(paddr[4:2]))
        REG_SMA:   sma  <= pwdata;
        REG_ECC:   ecc  <= pwdata[15:0];
        REG_INC:   inc  <= pwdata[15:0];
        REG_NODE:  node <= pwdata[15:0];
        REG_PERI:  peri <= pwdata[15:0];
        REG_COUNT: cnt  <= pwdata[16:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_index_t'(paddr[4:2]))
      REG_SMA:   prdata = sma;
      REG_ECC:   prdata = {16'd0, ecc};
      REG_INC:   prdata = {16'd0, inc};
      REG_NODE:  prdata = {16'd0, node};
      REG_PERI:  prdata = {16'd0, peri};
      REG_COUNT: prdata = {15'd0, cnt};
      default:   prdata = '0;
    endcase
  end

  // Pipeline control: all stages move together unless the skid register is full.
  logic            en;
  logic [NSTG-1:0] v;
  logic            skid_v;

  assign en       = !skid_v;
  assign in_stall = skid_v;

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (en) begin
      v <= {v[NSTG-2:0], in_valid};
    end
  end

  // Angle of the point: floor(index * 2^32 / count) modulo a full turn.
  logic [16:0] cnt_eff;
  logic [31:0] theta;

  assign cnt_eff = (cnt == 17'd0) ? 17'd1 : cnt;

  opg_div #(
    .NBITS(THETA_BITS),
    .RW(17),
    .QW(32),
    .SPS(DIV_SPS)
  ) u_theta_div (
    .clk(clk),
    .stage_en({ND{en}}),
    .rem_in(17'd0),
    .bits_in({point_index[INDEX_WIDTH-1:0], 32'd0}),
    .divisor(cnt_eff),
    .quotient(theta)
  );

  trig_t ct, st, cw, sw, ci, si, cn, sn;

  opg_cordic #(.ITERATIONS(TRIG_ITERATIONS)) u_theta_trig (
    .clk(clk),
    .stage_en({NC{en}}),
    .angle(theta),
    .cos_val(ct),
    .sin_val(st)
  );

  // The register angles run through free-running units of their own.
  opg_cordic #(.ITERATIONS(TRIG_ITERATIONS)) u_peri_trig (
    .clk(clk),
    .stage_en({NC{1'b1}}),
    .angle({peri, 16'd0}),
    .cos_val(cw),
    .sin_val(sw)
  );

  opg_cordic #(.ITERATIONS(TRIG_ITERATIONS)) u_inc_trig (
    .clk(clk),
    .stage_en({NC{1'b1}}),
    .angle({inc, 16'd0}),
    .cos_val(ci),
    .sin_val(si)
  );

  opg_cordic #(.ITERATIONS(TRIG_ITERATIONS)) u_node_trig (
    .clk(clk),
    .stage_en({NC{1'b1}}),
    .angle({node, 16'd0}),
    .cos_val(cn),
    .sin_val(sn)
  );

  // The point's cosine and sine travel beside the radius computation.
  trig_t ct_pipe [S_RP0:S_M0-1];
  trig_t st_pipe [S_RP0:S_M0-1];

  for (genvar k = S_RP0; k < S_M0; k++) begin : g_trig_carry
    if (k == S_RP0) begin : g_first
      always_ff @(posedge clk) begin
        if (en) begin
          ct_pipe[k] <= ct;
          st_pipe[k] <= st;
        end
      end
    end else begin : g_next
      always_ff @(posedge clk) begin
        if (en) begin
          ct_pipe[k] <= ct_pipe[k-1];
          st_pipe[k] <= st_pipe[k-1];
        end
      end
    end
  end

  // Elliptical radius: a(1 - e^2) / (1 + e cos theta).
  logic signed [16:0] ecc_s;
  logic signed [48:0] rp0_ect;
  logic [31:0]        rp0_esq;
  logic [32:0]        ome;
  logic [64:0]        num_full;
  logic signed [34:0] rp1_den;
  logic [64:0]        rp1_num;
  logic               den_ok;
  logic               rp2_sat;
  logic [34:0]        rp2_rem;
  logic [39:0]        rp2_bits;
  logic [34:0]        rp2_dvs;
  logic [39:0]        rad_q;

  assign ecc_s    = {1'b0, ecc};
  assign ome      = 33'h1_0000_0000 - {1'b0, rp0_esq};
  assign num_full = sma * ome;
  assign den_ok   = !rp1_den[34] && (rp1_den != 35'sd0);

  always_ff @(posedge clk) begin
    if (en) begin
      rp0_ect  <= ecc_s * ct;
      rp0_esq  <= ecc * ecc;
      rp1_den  <= $signed(rp0_ect[48:14]) + 35'sh1_0000_0000;
      rp1_num  <= num_full;
      // A quotient at or above 2^40 shows as the top bits reaching the divisor.
      rp2_sat  <= !den_ok || ({10'd0, rp1_num[64:40]} >= rp1_den);
      rp2_rem  <= {10'd0, rp1_num[64:40]};
      rp2_bits <= rp1_num[39:0];
      rp2_dvs  <= rp1_den;
    end
  end

  opg_div #(
    .NBITS(RAD_BITS),
    .RW(35),
    .QW(RAD_BITS),
    .SPS(RAD_SPS)
  ) u_rad_div (
    .clk(clk),
    .stage_en({NR{en}}),
    .rem_in(rp2_rem),
    .bits_in(rp2_bits),
    .divisor(rp2_dvs),
    .quotient(rad_q)
  );

  logic sat_pipe [NR];

  always_ff @(posedge clk) begin
    if (en) begin
      sat_pipe[0] <= rp2_sat;
      for (int k = 1; k < NR; k++) begin
        sat_pipe[k] <= sat_pipe[k-1];
      end
    end
  end

  // Rotation chain, each product split over a multiply stage and an add stage.
  coord_t r_sel;
  logic   r_clip;
  pp_t    m0_x, m0_y;
  coord_t m1_x, m1_y;
  pp_t    m2_xcw, m2_ysw, m2_xsw, m2_ycw;
  coord_t m3_x1, m3_y1;
  pp_t    m4_y1ci, m4_y1si;
  coord_t m4_x1;
  coord_t m5_x1, m5_y2, m5_z2;
  pp_t    m6_x1cn, m6_y2sn, m6_x1sn, m6_y2cn;
  coord_t m6_z2;
  coord_t m7_x3, m7_y3, m7_z2;
  wide_t  e0_x, e0_z, e0_y;
  logic   m_sat [9];
  emit_t  cx, cz, cy;

  assign r_clip = (ecc != 16'd0) && sat_pipe[NR-1];

  always_comb begin
    if (ecc == 16'd0) begin
      r_sel = {{(COORD_W-32){1'b0}}, sma};
    end else if (sat_pipe[NR-1]) begin
      r_sel = {{(COORD_W-40){1'b0}}, RADIUS_LIMIT};
    end else begin
      r_sel = {{(COORD_W-40){1'b0}}, rad_q};
    end
  end

  assign cx = clamp_out(e0_x);
  assign cz = clamp_out(e0_z);
  assign cy = clamp_out(e0_y);

  logic [47:0] p_x, p_up, p_depth;
  logic        p_sat;

  always_ff @(posedge clk) begin
    if (en) begin
      m0_x    <= pp_mul(r_sel, ct_pipe[S_M0-1]);
      m0_y    <= pp_mul(r_sel, st_pipe[S_M0-1]);
      m1_x    <= pp_join(m0_x);
      m1_y    <= pp_join(m0_y);
      m2_xcw  <= pp_mul(m1_x, cw);
      m2_ysw  <= pp_mul(m1_y, sw);
      m2_xsw  <= pp_mul(m1_x, sw);
      m2_ycw  <= pp_mul(m1_y, cw);
      m3_x1   <= pp_join(m2_xcw) - pp_join(m2_ysw);
      m3_y1   <= pp_join(m2_xsw) + pp_join(m2_ycw);
      m4_y1ci <= pp_mul(m3_y1, ci);
      m4_y1si <= pp_mul(m3_y1, si);
      m4_x1   <= m3_x1;
      m5_y2   <= pp_join(m4_y1ci);
      m5_z2   <= pp_join(m4_y1si);
      m5_x1   <= m4_x1;
      m6_x1cn <= pp_mul(m5_x1, cn);
      m6_y2sn <= pp_mul(m5_y2, sn);
      m6_x1sn <= pp_mul(m5_x1, sn);
      m6_y2cn <= pp_mul(m5_y2, cn);
      m6_z2   <= m5_z2;
      m7_x3   <= pp_join(m6_x1cn) - pp_join(m6_y2sn);
      m7_y3   <= pp_join(m6_x1sn) + pp_join(m6_y2cn);
      m7_z2   <= m6_z2;
      e0_x    <= times_1000(m7_x3);
      e0_z    <= times_1000(m7_z2);
      e0_y    <= times_1000(m7_y3);
      m_sat[0] <= r_clip;
      for (int k = 1; k < 9; k++) begin
        m_sat[k] <= m_sat[k-1];
      end
      p_x     <= cx.value;
      p_up    <= cz.value;
      p_depth <= cy.value;
      p_sat   <= m_sat[8] || cx.clip || cz.clip || cy.clip;
    end
  end

  // Output register with one skid entry behind it.
  logic [47:0] s_x, s_up, s_depth;
  logic        s_sat;
  logic        out_take;

  assign out_take = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      skid_v    <= 1'b0;
    end else if (out_take) begin
      out_valid <= skid_v || v[NSTG-1];
      skid_v    <= 1'b0;
    end else if (!skid_v && v[NSTG-1]) begin
      skid_v <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_take) begin
      pos_x     <= skid_v ? s_x : p_x;
      pos_up    <= skid_v ? s_up : p_up;
      pos_depth <= skid_v ? s_depth : p_depth;
      saturated <= skid_v ? s_sat : p_sat;
    end
    if (!out_take && !skid_v) begin
      s_x     <= p_x;
      s_up    <= p_up;
      s_depth <= p_depth;
      s_sat   <= p_sat;
    end
  end

endmodule

`default_nettype wire
